// ===== sv/lnpp_pkg.sv =====
// ----------------------------------------------------------------------------
// lnpp_pkg - shared types and tables for the LED notification pattern player
// Register codes, pattern selects, config/result structs and the step tables.
// ----------------------------------------------------------------------------
`default_nettype none

package lnpp_pkg;

	localparam int unsigned IntervalWidth = 16;
	localparam int unsigned DurWidth      = 9;
	localparam int unsigned StepWidth     = 5;
	localparam int unsigned KindWidth     = 2;
	localparam int unsigned MaskWidth     = 3;
	localparam int unsigned CfgIdxWidth   = 3;

	// Item kinds carried in tuser
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_EVENT = 1'b1;

	// Event kinds
	localparam logic [KindWidth-1:0] KIND_SOS    = 2'd1;
	localparam logic [KindWidth-1:0] KIND_INVITE = 2'd2;

	// Mask bits
	localparam int unsigned MASK_LED = 0;
	localparam int unsigned MASK_BUZ = 1;
	localparam int unsigned MASK_VIB = 2;

	// Configuration register indexes
	localparam logic [CfgIdxWidth-1:0] REG_LED_EN      = 3'd0;
	localparam logic [CfgIdxWidth-1:0] REG_BUZ_EN      = 3'd1;
	localparam logic [CfgIdxWidth-1:0] REG_VIB_EN      = 3'd2;
	localparam logic [CfgIdxWidth-1:0] REG_EVENT_MASK  = 3'd3;
	localparam logic [CfgIdxWidth-1:0] REG_HB_INTERVAL = 3'd4;

	localparam logic [IntervalWidth-1:0] HB_INTERVAL_RST = 16'd5000;

	typedef enum logic [1:0] {
		SEL_MESSAGE = 2'd0,
		SEL_SOS     = 2'd1,
		SEL_INVITE  = 2'd2,
		SEL_HEART   = 2'd3
	} sel_t;

	typedef struct packed {
		logic                     led_en;
		logic                     buz_en;
		logic                     vib_en;
		logic [MaskWidth-1:0]     event_mask;
		logic [IntervalWidth-1:0] hb_interval;
	} cfg_t;

	typedef struct packed {
		logic vibration_request;
		logic buzzer_request;
		logic pattern_active;
		logic led_on;
	} res_t;

	// Number of steps in each pattern
	function automatic logic [StepWidth-1:0] pat_len(input sel_t sel);
		logic [StepWidth-1:0] n;
		case (sel)
			SEL_MESSAGE: n = 5'd4;
			SEL_SOS:     n = 5'd18;
			SEL_INVITE:  n = 5'd6;
			SEL_HEART:   n = 5'd2;
			default:     n = 5'd2;
		endcase
		return n;
	endfunction

	// Duration in ms of one step; steps alternate on/off starting with on
	function automatic logic [DurWidth-1:0] step_dur(input sel_t sel,
		input logic [StepWidth-1:0] idx);
		logic [DurWidth-1:0] d;
		case (sel)
			SEL_MESSAGE: d = 9'd200;
			SEL_SOS: begin
				if (idx >= 5'd17) begin
					d = 9'd200;
				end else if (idx == 5'd5 || idx == 5'd6 || idx == 5'd8 ||
					idx == 5'd10 || idx == 5'd11) begin
					d = 9'd300;
				end else begin
					d = 9'd100;
				end
			end
			SEL_INVITE: begin
				if (idx >= 5'd5) begin
					d = 9'd200;
				end else if (idx[0]) begin
					d = 9'd100;
				end else begin
					d = 9'd150;
				end
			end
			SEL_HEART: d = 9'd80;
			default:   d = 9'd80;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== sv/lnpp_core.sv =====
// ----------------------------------------------------------------------------
// lnpp_core - pattern and heartbeat state
// Holds the player state and works out the result of one item per cycle while step_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lnpp_core (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   step_en,
	input  wire                                   op,
	input  wire  [lnpp_pkg::KindWidth-1:0]        event_kind,
	input  lnpp_pkg::cfg_t                        cfg,
	output lnpp_pkg::res_t                        res
);

	logic                                 playing_q;
	lnpp_pkg::sel_t                       sel_q;
	logic [lnpp_pkg::StepWidth-1:0]       idx_q;
	logic [lnpp_pkg::DurWidth-1:0]        rem_q;
	logic [lnpp_pkg::IntervalWidth-1:0]   elapsed_q;
	logic                                 led_q;

	logic                                 playing_d;
	lnpp_pkg::sel_t                       sel_d;
	logic [lnpp_pkg::StepWidth-1:0]       idx_d;
	logic [lnpp_pkg::DurWidth-1:0]        rem_d;
	logic [lnpp_pkg::IntervalWidth-1:0]   elapsed_d;
	logic                                 led_d;
	logic [lnpp_pkg::DurWidth-1:0]        rem_dec;
	logic [lnpp_pkg::StepWidth-1:0]       idx_inc;
	logic [lnpp_pkg::IntervalWidth-1:0]   elapsed_inc;
	lnpp_pkg::sel_t                       ev_sel;
	logic                                 buz_d;
	logic                                 vib_d;

	always_comb begin
		playing_d = playing_q;
		sel_d     = sel_q;
		idx_d     = idx_q;
		rem_d     = rem_q;
		elapsed_d = elapsed_q;
		led_d     = led_q;
		buz_d     = 1'b0;
		vib_d     = 1'b0;
		rem_dec     = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
		idx_inc     = idx_q + 1'b1;
		elapsed_inc = (elapsed_q < cfg.hb_interval) ? elapsed_q + 1'b1 : cfg.hb_interval;

		if (event_kind == lnpp_pkg::KIND_SOS) begin
			ev_sel = lnpp_pkg::SEL_SOS;
		end else if (event_kind == lnpp_pkg::KIND_INVITE) begin
			ev_sel = lnpp_pkg::SEL_INVITE;
		end else begin
			ev_sel = lnpp_pkg::SEL_MESSAGE;
		end

		if (op == lnpp_pkg::OP_EVENT) begin
			if (cfg.led_en && cfg.event_mask[lnpp_pkg::MASK_LED]) begin
				playing_d = 1'b1;
				sel_d     = ev_sel;
				idx_d     = '0;
				rem_d     = lnpp_pkg::step_dur(ev_sel, '0);
				led_d     = 1'b1;
			end
			buz_d = cfg.buz_en && cfg.event_mask[lnpp_pkg::MASK_BUZ];
			vib_d = cfg.vib_en && cfg.event_mask[lnpp_pkg::MASK_VIB];
		end else begin
			// countdown first
			if (playing_q) begin
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					if (idx_inc >= lnpp_pkg::pat_len(sel_q)) begin
						playing_d = 1'b0;
						idx_d     = '0;
						led_d     = 1'b0;
					end else begin
						idx_d = idx_inc;
						rem_d = lnpp_pkg::step_dur(sel_q, idx_inc);
						led_d = ~idx_inc[0];
					end
				end
			end
			// then the heartbeat, which overrides any running pattern
			elapsed_d = elapsed_inc;
			if (cfg.led_en && elapsed_inc == cfg.hb_interval) begin
				elapsed_d = '0;
				playing_d = 1'b1;
				sel_d     = lnpp_pkg::SEL_HEART;
				idx_d     = '0;
				rem_d     = lnpp_pkg::step_dur(lnpp_pkg::SEL_HEART, '0);
				led_d     = 1'b1;
			end
		end

		res.led_on            = led_d;
		res.pattern_active    = playing_d;
		res.buzzer_request    = buz_d;
		res.vibration_request = vib_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			sel_q     <= lnpp_pkg::SEL_MESSAGE;
			idx_q     <= '0;
			rem_q     <= '0;
			elapsed_q <= '0;
			led_q     <= 1'b0;
		end else if (step_en) begin
			playing_q <= playing_d;
			sel_q     <= sel_d;
			idx_q     <= idx_d;
			rem_q     <= rem_d;
			elapsed_q <= elapsed_d;
			led_q     <= led_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/led_notify_pattern_player.sv =====
// ----------------------------------------------------------------------------
// led_notify_pattern_player - LED notification pattern player
// Plays LED on/off patterns on notification events and a periodic heartbeat.
// ----------------------------------------------------------------------------
// Each input word is either a one-millisecond tick (tuser 0) or a notification
// event (tuser 1, event kind in tdata). Every input word yields exactly one
// output word with the LED level, the pattern-active flag and one-word buzzer
// and vibration request pulses. The block takes one word per cycle while the
// output is not stalled; an accepted word passes the input register, then the
// result register, and all state update happens in the single logic step
// between them. Backpressure on the output stalls the input register,
// so no word is ever dropped. Configuration registers (index: 0 LED enable,
// 1 buzzer enable, 2 vibration enable, 3 event mask, 4 heartbeat interval)
// are written through the cfg channel, which is always ready; write them only
// while no word is in flight. Indexes above 4 are ignored.
`default_nettype none

module led_notify_pattern_player (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration write channel
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [lnpp_pkg::CfgIdxWidth-1:0]      cfg_index,
	input  wire  [lnpp_pkg::IntervalWidth-1:0]    cfg_data,
	// input stream
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [7:0]                            s_tdata,  // [1:0] event_kind, rest zero
	input  wire                                   s_tuser,  // [0] op
	// result stream
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	output logic [7:0]                            m_tdata   // [0] led_on, [1] pattern_active,
	                                                        // [2] buzzer_request,
	                                                        // [3] vibration_request
);

	lnpp_pkg::cfg_t                       cfg_q;
	logic                                 v_s1;
	logic                                 op_s1;
	logic [lnpp_pkg::KindWidth-1:0]       kind_s1;
	logic                                 out_v_q;
	lnpp_pkg::res_t                       res_q;
	lnpp_pkg::res_t                       res_d;
	logic                                 adv;
	logic                                 step_en;

	// advance the result stage when it is empty or being drained
	assign adv       = !out_v_q || m_tready;
	assign s_tready  = !v_s1 || adv;
	assign step_en   = v_s1 && adv;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = {4'd0, res_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_en      <= 1'b1;
			cfg_q.buz_en      <= 1'b1;
			cfg_q.vib_en      <= 1'b1;
			cfg_q.event_mask  <= '1;
			cfg_q.hb_interval <= lnpp_pkg::HB_INTERVAL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				lnpp_pkg::REG_LED_EN:      cfg_q.led_en      <= cfg_data[0];
				lnpp_pkg::REG_BUZ_EN:      cfg_q.buz_en      <= cfg_data[0];
				lnpp_pkg::REG_VIB_EN:      cfg_q.vib_en      <= cfg_data[0];
				lnpp_pkg::REG_EVENT_MASK:  cfg_q.event_mask  <=
					cfg_data[lnpp_pkg::MaskWidth-1:0];
				lnpp_pkg::REG_HB_INTERVAL: cfg_q.hb_interval <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: hold the word while the result stage is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			kind_s1 <= s_tdata[lnpp_pkg::KindWidth-1:0];
		end
	end

	lnpp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.op         (op_s1),
		.event_kind (kind_s1),
		.cfg        (cfg_q),
		.res        (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res_d;
		end
	end

	// a tick never requests the buzzer or the vibrator
	a_tick_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && op_s1 == lnpp_pkg::OP_TICK) |=>
		(!res_q.buzzer_request && !res_q.vibration_request))
		else $error("request pulse on a tick");

	// an enabled event starts a pattern with the LED on
	a_event_start: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && op_s1 == lnpp_pkg::OP_EVENT && cfg_q.led_en &&
		cfg_q.event_mask[lnpp_pkg::MASK_LED]) |=>
		(res_q.pattern_active && res_q.led_on))
		else $error("event did not start a pattern");

	// the LED is only lit while a pattern plays
	a_led_needs_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !res_q.pattern_active) |-> !res_q.led_on)
		else $error("LED on with no pattern playing");

	// an empty result stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> s_tready)
		else $error("input stalled with empty result stage");

endmodule

`default_nettype wire

// ===== sim/tb_led_notify_pattern_player.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_notify_pattern_player - self-checking bench for the LED pattern player
// Streams ticks and notification events into the block under random idling on
// both sides, predicts every result word from a local copy of the player state
// and configuration, and compares each result field by field in order.
// ----------------------------------------------------------------------------

module tb_led_notify_pattern_player;

	// event kinds that the package leaves unnamed
	localparam logic [lnpp_pkg::KindWidth-1:0] KIND_MESSAGE = 2'd0;
	localparam logic [lnpp_pkg::KindWidth-1:0] KIND_UNKNOWN = 2'd3;

	localparam int IdlePct      = 29;
	localparam int QuietLimit   = 4000;   // cycles with no word or write moving
	localparam int RandomTarget = 1200;

	typedef struct {
		logic                           op;
		logic [lnpp_pkg::KindWidth-1:0] kind;
	} stim_word_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [lnpp_pkg::CfgIdxWidth-1:0]   cfg_index = '0;
	logic [lnpp_pkg::IntervalWidth-1:0] cfg_data = '0;
	logic                               s_tvalid = 1'b0;
	logic                               s_tready;
	logic [7:0]                         s_tdata = '0;    // [1:0] event_kind, rest zero
	logic                               s_tuser = 1'b0;  // [0] op
	logic                               m_tvalid;
	logic                               m_tready = 1'b0;
	logic [7:0]                         m_tdata;         // [0] led_on, [1] pattern_active,
	                                                     // [2] buzzer_request,
	                                                     // [3] vibration_request

	led_notify_pattern_player u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ------------------------------------------------------------------------
	// Player state as the bench sees it
	// ------------------------------------------------------------------------
	lnpp_pkg::cfg_t                     player_cfg = '{led_en: 1'b1, buz_en: 1'b1,
		vib_en: 1'b1, event_mask: 3'b111, hb_interval: lnpp_pkg::HB_INTERVAL_RST};
	logic                               playing = 1'b0;
	lnpp_pkg::sel_t                     cur_pattern = lnpp_pkg::SEL_MESSAGE;
	logic [lnpp_pkg::StepWidth-1:0]     cur_step = '0;
	logic [lnpp_pkg::DurWidth-1:0]      ms_left = '0;
	logic [lnpp_pkg::IntervalWidth-1:0] hb_elapsed = '0;
	logic                               led_level = 1'b0;

	logic [lnpp_pkg::DurWidth-1:0] sos_ms [0:17] = '{9'd100, 9'd100, 9'd100, 9'd100,
		9'd100, 9'd300, 9'd300, 9'd100, 9'd300, 9'd100, 9'd300, 9'd300, 9'd100, 9'd100,
		9'd100, 9'd100, 9'd100, 9'd200};
	logic [lnpp_pkg::DurWidth-1:0] invite_ms [0:5] = '{9'd150, 9'd100, 9'd150, 9'd100,
		9'd150, 9'd200};

	stim_word_t     outgoing_words[$];
	lnpp_pkg::res_t pending_outputs[$];
	stim_word_t     next_word;
	int             mismatches = 0;
	int             quiet_cycles = 0;
	int             words_queued = 0;
	bit             gapless = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [lnpp_pkg::StepWidth-1:0] steps_in(input lnpp_pkg::sel_t s);
		case (s)
			lnpp_pkg::SEL_SOS:    return 5'd18;
			lnpp_pkg::SEL_INVITE: return 5'd6;
			lnpp_pkg::SEL_HEART:  return 5'd2;
			default:              return 5'd4;
		endcase
	endfunction

	function automatic logic [lnpp_pkg::DurWidth-1:0] step_ms(input lnpp_pkg::sel_t s,
		input logic [lnpp_pkg::StepWidth-1:0] i);
		case (s)
			lnpp_pkg::SEL_SOS:    return sos_ms[(i > 5'd17) ? 5'd17 : i];
			lnpp_pkg::SEL_INVITE: return invite_ms[(i > 5'd5) ? 5'd5 : i];
			lnpp_pkg::SEL_HEART:  return 9'd80;
			default:              return 9'd200;
		endcase
	endfunction

	// load the current step; even steps light the LED
	task automatic load_step();
		ms_left   = step_ms(cur_pattern, cur_step);
		led_level = ~cur_step[0];
	endtask

	task automatic start_pattern(input lnpp_pkg::sel_t s);
		cur_pattern = s;
		cur_step    = '0;
		playing     = 1'b1;
		load_step();
	endtask

	// Advance the player by one accepted word and queue the result it yields.
	task automatic play_word(input logic op, input logic [lnpp_pkg::KindWidth-1:0] kind);
		lnpp_pkg::res_t r;
		r = '0;
		if (op == lnpp_pkg::OP_EVENT) begin
			// unknown kinds fall back to the message pattern
			if (player_cfg.led_en && player_cfg.event_mask[lnpp_pkg::MASK_LED]) begin
				case (kind)
					lnpp_pkg::KIND_SOS:    start_pattern(lnpp_pkg::SEL_SOS);
					lnpp_pkg::KIND_INVITE: start_pattern(lnpp_pkg::SEL_INVITE);
					default:               start_pattern(lnpp_pkg::SEL_MESSAGE);
				endcase
			end
			r.buzzer_request    = player_cfg.buz_en &&
				player_cfg.event_mask[lnpp_pkg::MASK_BUZ];
			r.vibration_request = player_cfg.vib_en &&
				player_cfg.event_mask[lnpp_pkg::MASK_VIB];
		end else begin
			// countdown first
			if (playing) begin
				if (ms_left != '0) ms_left = ms_left - 1'b1;
				if (ms_left == '0) begin
					cur_step = cur_step + 1'b1;
					if (cur_step >= steps_in(cur_pattern)) begin
						playing   = 1'b0;
						cur_step  = '0;
						led_level = 1'b0;
					end else begin
						load_step();
					end
				end
			end
			// then the heartbeat; the count saturates at the interval and is
			// clamped when the interval was lowered under it
			if (hb_elapsed < player_cfg.hb_interval) hb_elapsed = hb_elapsed + 1'b1;
			if (hb_elapsed > player_cfg.hb_interval) hb_elapsed = player_cfg.hb_interval;
			if (player_cfg.led_en && hb_elapsed >= player_cfg.hb_interval) begin
				hb_elapsed = '0;
				start_pattern(lnpp_pkg::SEL_HEART);
			end
		end
		r.led_on         = led_level;
		r.pattern_active = playing;
		pending_outputs.push_back(r);
	endtask

	task automatic note_failure(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_result(input logic [7:0] word);
		lnpp_pkg::res_t want;
		if (pending_outputs.size() == 0) begin
			note_failure($sformatf("result word 0x%02h with nothing pending", word));
		end else begin
			want = pending_outputs.pop_front();
			if (word[0] !== want.led_on)
				note_failure($sformatf("led_on got %b want %b", word[0], want.led_on));
			if (word[1] !== want.pattern_active)
				note_failure($sformatf("pattern_active got %b want %b", word[1],
					want.pattern_active));
			if (word[2] !== want.buzzer_request)
				note_failure($sformatf("buzzer_request got %b want %b", word[2],
					want.buzzer_request));
			if (word[3] !== want.vibration_request)
				note_failure($sformatf("vibration_request got %b want %b", word[3],
					want.vibration_request));
			if (word[7:4] !== 4'd0)
				note_failure($sformatf("padding bits got %b", word[7:4]));
		end
	endtask

	// ------------------------------------------------------------------------
	// Prediction: track every accepted word and every register write
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				lnpp_pkg::REG_LED_EN:      player_cfg.led_en      = cfg_data[0];
				lnpp_pkg::REG_BUZ_EN:      player_cfg.buz_en      = cfg_data[0];
				lnpp_pkg::REG_VIB_EN:      player_cfg.vib_en      = cfg_data[0];
				lnpp_pkg::REG_EVENT_MASK:  player_cfg.event_mask  =
					cfg_data[lnpp_pkg::MaskWidth-1:0];
				lnpp_pkg::REG_HB_INTERVAL: player_cfg.hb_interval = cfg_data;
				default: ;
			endcase
		end
		if (arst_n && s_tvalid && s_tready)
			play_word(s_tuser, s_tdata[lnpp_pkg::KindWidth-1:0]);
	end

	// ------------------------------------------------------------------------
	// Driver: present the next queued word, hold it until taken, idle at random
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= lnpp_pkg::OP_TICK;
		end else if (!s_tvalid || s_tready) begin
			if (outgoing_words.size() != 0 && (gapless || $urandom_range(99) >= IdlePct)) begin
				next_word = outgoing_words.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= next_word.op;
				s_tdata  <= {6'd0, next_word.kind};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: random backpressure, check every result word taken
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= gapless || ($urandom_range(99) >= IdlePct);
			if (m_tvalid && m_tready) check_result(m_tdata);
		end
	end

	// Watchdog: end the run when nothing has moved for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("tb_led_notify_pattern_player NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic add_word(input logic op, input logic [lnpp_pkg::KindWidth-1:0] kind);
		stim_word_t w;
		w.op   = op;
		w.kind = kind;
		outgoing_words.push_back(w);
		words_queued++;
	endtask

	// hold until every word is sent and answered, then let the pipe settle;
	// sample between edges so the driver and monitor have settled
	task automatic wait_idle();
		@(negedge clk);
		while (outgoing_words.size() != 0 || s_tvalid || pending_outputs.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lnpp_pkg::CfgIdxWidth-1:0] idx,
		input logic [lnpp_pkg::IntervalWidth-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic led, input logic buz, input logic vib,
		input logic [lnpp_pkg::MaskWidth-1:0] mask,
		input logic [lnpp_pkg::IntervalWidth-1:0] interval);
		write_reg(lnpp_pkg::REG_LED_EN, {15'd0, led});
		write_reg(lnpp_pkg::REG_BUZ_EN, {15'd0, buz});
		write_reg(lnpp_pkg::REG_VIB_EN, {15'd0, vib});
		write_reg(lnpp_pkg::REG_EVENT_MASK, {13'd0, mask});
		write_reg(lnpp_pkg::REG_HB_INTERVAL, interval);
	endtask

	// queue a run of mostly ticks with events sprinkled in, then drain
	task automatic run_phase(input int count, input int event_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < event_pct)
				add_word(lnpp_pkg::OP_EVENT, lnpp_pkg::KindWidth'($urandom_range(3)));
			else
				add_word(lnpp_pkg::OP_TICK, lnpp_pkg::KindWidth'($urandom_range(3)));
		end
		wait_idle();
	endtask

	initial begin
		logic [lnpp_pkg::IntervalWidth-1:0] interval;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every event kind from reset, restarts while a pattern plays
		add_word(lnpp_pkg::OP_EVENT, KIND_MESSAGE);
		add_word(lnpp_pkg::OP_TICK, KIND_UNKNOWN);
		add_word(lnpp_pkg::OP_TICK, KIND_MESSAGE);
		add_word(lnpp_pkg::OP_EVENT, lnpp_pkg::KIND_SOS);
		add_word(lnpp_pkg::OP_TICK, lnpp_pkg::KIND_SOS);
		add_word(lnpp_pkg::OP_EVENT, lnpp_pkg::KIND_INVITE);
		add_word(lnpp_pkg::OP_TICK, lnpp_pkg::KIND_INVITE);
		add_word(lnpp_pkg::OP_EVENT, KIND_UNKNOWN);
		add_word(lnpp_pkg::OP_TICK, KIND_MESSAGE);
		wait_idle();

		// mask extremes and single request paths
		write_reg(lnpp_pkg::REG_EVENT_MASK, 16'd0);
		add_word(lnpp_pkg::OP_EVENT, lnpp_pkg::KIND_SOS);
		add_word(lnpp_pkg::OP_TICK, KIND_MESSAGE);
		wait_idle();
		write_reg(lnpp_pkg::REG_EVENT_MASK, 16'd2);
		add_word(lnpp_pkg::OP_EVENT, KIND_MESSAGE);
		wait_idle();
		write_reg(lnpp_pkg::REG_EVENT_MASK, 16'd5);
		add_word(lnpp_pkg::OP_EVENT, lnpp_pkg::KIND_INVITE);
		add_word(lnpp_pkg::OP_TICK, KIND_MESSAGE);
		wait_idle();

		// LED off mid-pattern: the pattern keeps playing, new starts are blocked
		write_all(1'b0, 1'b0, 1'b1, 3'd7, lnpp_pkg::HB_INTERVAL_RST);
		add_word(lnpp_pkg::OP_TICK, KIND_MESSAGE);
		add_word(lnpp_pkg::OP_EVENT, lnpp_pkg::KIND_SOS);
		wait_idle();

		// tiny and zero heartbeat intervals
		write_all(1'b1, 1'b1, 1'b0, 3'd7, 16'd1);
		add_word(lnpp_pkg::OP_TICK, KIND_MESSAGE);
		add_word(lnpp_pkg::OP_TICK, KIND_MESSAGE);
		add_word(lnpp_pkg::OP_EVENT, lnpp_pkg::KIND_INVITE);
		add_word(lnpp_pkg::OP_TICK, KIND_MESSAGE);
		wait_idle();
		write_reg(lnpp_pkg::REG_HB_INTERVAL, 16'd0);
		add_word(lnpp_pkg::OP_TICK, lnpp_pkg::KIND_SOS);
		add_word(lnpp_pkg::OP_TICK, KIND_MESSAGE);
		wait_idle();

		words_queued = 0;

		// long stretch with no idling on either side
		gapless = 1'b1;
		write_all(1'b1, 1'b1, 1'b1, 3'd7, 16'd200);
		run_phase(120, 8);
		gapless = 1'b0;

		// let the count climb under the largest interval, then drop the
		// interval below it so the heartbeat fires on the next tick
		write_reg(lnpp_pkg::REG_HB_INTERVAL, 16'hFFFF);
		run_phase(120, 6);
		write_reg(lnpp_pkg::REG_HB_INTERVAL, 16'd40);
		run_phase(100, 8);

		// start an invite, then block the heartbeat so the steps run long
		write_all(1'b1, 1'b1, 1'b1, 3'd7, 16'hFFFF);
		add_word(lnpp_pkg::OP_EVENT, lnpp_pkg::KIND_INVITE);
		wait_idle();
		write_reg(lnpp_pkg::REG_LED_EN, 16'd0);
		run_phase(300, 3);

		// random settings until the budget is spent
		while (words_queued < RandomTarget) begin
			case ($urandom_range(9))
				0:       interval = 16'd0;
				1:       interval = 16'd1;
				2:       interval = 16'hFFFF;
				default: interval = lnpp_pkg::IntervalWidth'($urandom_range(400, 20));
			endcase
			write_all($urandom_range(99) < 80, 1'($urandom_range(1)), 1'($urandom_range(1)),
				lnpp_pkg::MaskWidth'($urandom_range(7)), interval);
			run_phase($urandom_range(120, 40), 8);
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("tb_led_notify_pattern_player OK");
		end else begin
			$display("tb_led_notify_pattern_player NOT OK");
		end
		$finish;
	end

endmodule
